// ===== rtl/atr_pkg.sv =====
// Package: shared types and phase codes for the answer-to-reset parser.
`timescale 1ns / 1ps
package atr_pkg;

    typedef enum logic [2:0] {
        PH_INITIAL = 3'd0,
        PH_FORMAT  = 3'd1,
        PH_LEVEL1  = 3'd2,
        PH_LEVEL2  = 3'd3,
        PH_HIST    = 3'd4,
        PH_TAIL    = 3'd5
    } atr_phase_t;

    localparam logic [7:0] HIGH_NIBBLE_MASK = 8'hF0;
    localparam logic [7:0] LOW_NIBBLE_MASK  = 8'h0F;
    localparam logic [7:0] MATCH_FORMAT_HI  = 8'h60;
    localparam logic [7:0] MATCH_B_VALUE    = 8'h00;

    typedef struct packed {
        logic       status;
        logic       card_match;
        logic [7:0] format_byte;
        logic [3:0] historical_count;
        logic [3:0] level_one_mask;
        logic [3:0] level_two_mask;
        logic [7:0] first_interface_byte;
        logic [7:0] second_interface_byte;
        logic [7:0] third_interface_byte;
        logic [7:0] fourth_interface_byte;
    } atr_result_t;

endpackage

// ===== rtl/atr_if.sv =====
// Interfaces: byte request channel and result request channel.
`timescale 1ns / 1ps
interface atr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] atr_byte;
    logic       last_byte;

    modport source (output valid, output atr_byte, output last_byte, input ready);
    modport sink   (input valid, input atr_byte, input last_byte, output ready);
endinterface

interface atr_result_if;
    logic       valid;
    logic       ready;
    logic       status;
    logic       card_match;
    logic [7:0] format_byte;
    logic [3:0] historical_count;
    logic [3:0] level_one_mask;
    logic [3:0] level_two_mask;
    logic [7:0] first_interface_byte;
    logic [7:0] second_interface_byte;
    logic [7:0] third_interface_byte;
    logic [7:0] fourth_interface_byte;

    modport source (
        output valid, input ready,
        output status, output card_match, output format_byte, output historical_count,
        output level_one_mask, output level_two_mask,
        output first_interface_byte, output second_interface_byte,
        output third_interface_byte, output fourth_interface_byte
    );
    modport sink (
        input valid, output ready,
        input status, input card_match, input format_byte, input historical_count,
        input level_one_mask, input level_two_mask,
        input first_interface_byte, input second_interface_byte,
        input third_interface_byte, input fourth_interface_byte
    );
endinterface

// ===== rtl/atr_parse_core.sv =====
// Parse core: phase state, captured fields and per-byte result logic.
`timescale 1ns / 1ps
module atr_parse_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  logic [7:0]           atr_byte,
    input  logic                 last_byte,
    output logic                 push,
    output atr_pkg::atr_result_t result
);

    atr_pkg::atr_phase_t phase_reg, phase_next;
    logic [3:0] pend_reg, pend_next;
    logic [3:0] hist_reg, hist_next;
    logic [7:0] fmt_reg, fmt_next;
    logic [7:0] l1_reg [4];
    logic [7:0] l1_next [4];
    logic [3:0] l1p_reg, l1p_next;
    logic [3:0] l2p_reg, l2p_next;
    logic [1:0] low_idx;
    logic       trunc;
    logic       match;

    function automatic logic [1:0] lowest_bit(input logic [3:0] m);
        logic [1:0] idx;
        idx = 2'd0;
        if (m[0])      idx = 2'd0;
        else if (m[1]) idx = 2'd1;
        else if (m[2]) idx = 2'd2;
        else if (m[3]) idx = 2'd3;
        return idx;
    endfunction

    assign low_idx = lowest_bit(pend_reg);

    always_comb
    begin
        phase_next = phase_reg;
        pend_next  = pend_reg;
        hist_next  = hist_reg;
        fmt_next   = fmt_reg;
        l1_next    = l1_reg;
        l1p_next   = l1p_reg;
        l2p_next   = l2p_reg;
        case (phase_reg)
            atr_pkg::PH_INITIAL:
            begin
                phase_next = atr_pkg::PH_FORMAT;
            end
            atr_pkg::PH_FORMAT:
            begin
                fmt_next  = atr_byte;
                pend_next = atr_byte[7:4];
                hist_next = atr_byte[3:0];
                if (atr_byte[7:4] != 4'd0)
                    phase_next = atr_pkg::PH_LEVEL1;
                else if (atr_byte[3:0] != 4'd0)
                    phase_next = atr_pkg::PH_HIST;
                else
                    phase_next = atr_pkg::PH_TAIL;
            end
            atr_pkg::PH_LEVEL1:
            begin
                l1_next[low_idx]   = atr_byte;
                l1p_next[low_idx]  = 1'b1;
                pend_next          = pend_reg;
                pend_next[low_idx] = 1'b0;
                if (low_idx == 2'd3)
                begin
                    pend_next = atr_byte[7:4];
                    if (atr_byte[7:4] != 4'd0)
                        phase_next = atr_pkg::PH_LEVEL2;
                    else
                        phase_next = (hist_reg != 4'd0) ? atr_pkg::PH_HIST
                                                         : atr_pkg::PH_TAIL;
                end
                else if (pend_next == 4'd0)
                begin
                    phase_next = (hist_reg != 4'd0) ? atr_pkg::PH_HIST : atr_pkg::PH_TAIL;
                end
            end
            atr_pkg::PH_LEVEL2:
            begin
                l2p_next[low_idx]  = 1'b1;
                pend_next[low_idx] = 1'b0;
                if (pend_next == 4'd0)
                    phase_next = (hist_reg != 4'd0) ? atr_pkg::PH_HIST : atr_pkg::PH_TAIL;
            end
            atr_pkg::PH_HIST:
            begin
                hist_next = hist_reg - 4'd1;
                if (hist_next == 4'd0)
                    phase_next = atr_pkg::PH_TAIL;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    assign trunc = (phase_next == atr_pkg::PH_FORMAT) || (phase_next == atr_pkg::PH_LEVEL1)
                || (phase_next == atr_pkg::PH_LEVEL2) || (phase_next == atr_pkg::PH_HIST);

    assign match = !trunc
                && ((fmt_next & atr_pkg::HIGH_NIBBLE_MASK) == atr_pkg::MATCH_FORMAT_HI)
                && l1p_next[1] && (l1_next[1] == atr_pkg::MATCH_B_VALUE)
                && l1p_next[2] && (l2p_next == 4'd0);

    assign push = take && last_byte;

    always_comb
    begin
        result.status                = trunc;
        result.card_match            = match;
        result.format_byte           = fmt_next;
        result.historical_count      = trunc ? 4'd0
                                             : fmt_next[3:0] & atr_pkg::LOW_NIBBLE_MASK[3:0];
        result.level_one_mask        = l1p_next;
        result.level_two_mask        = l2p_next;
        result.first_interface_byte  = l1_next[0];
        result.second_interface_byte = l1_next[1];
        result.third_interface_byte  = l1_next[2];
        result.fourth_interface_byte = l1_next[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= atr_pkg::PH_INITIAL;
            pend_reg  <= 4'd0;
            hist_reg  <= 4'd0;
            fmt_reg   <= 8'd0;
            l1_reg    <= '{default: 8'd0};
            l1p_reg   <= 4'd0;
            l2p_reg   <= 4'd0;
        end
        else if (take)
        begin
            if (last_byte)
            begin
                phase_reg <= atr_pkg::PH_INITIAL;
                pend_reg  <= 4'd0;
                hist_reg  <= 4'd0;
                fmt_reg   <= 8'd0;
                l1_reg    <= '{default: 8'd0};
                l1p_reg   <= 4'd0;
                l2p_reg   <= 4'd0;
            end
            else
            begin
                phase_reg <= phase_next;
                pend_reg  <= pend_next;
                hist_reg  <= hist_next;
                fmt_reg   <= fmt_next;
                l1_reg    <= l1_next;
                l1p_reg   <= l1p_next;
                l2p_reg   <= l2p_next;
            end
        end
    end

endmodule

// ===== rtl/atr_out_buf.sv =====
// Output stage: result register plus skid register.
`timescale 1ns / 1ps
module atr_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  atr_pkg::atr_result_t push_data,
    output logic                 can_push,
    output logic                 res_valid,
    input  logic                 res_ready,
    output atr_pkg::atr_result_t res_data
);

    logic                 main_valid_reg, main_valid_next;
    logic                 skid_valid_reg, skid_valid_next;
    atr_pkg::atr_result_t main_data_reg, main_data_next;
    atr_pkg::atr_result_t skid_data_reg, skid_data_next;
    logic                 pop;

    assign pop      = main_valid_reg && res_ready;
    assign can_push = !skid_valid_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_data_next  = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign res_valid = main_valid_reg;
    assign res_data  = main_data_reg;

endmodule

// ===== rtl/smart_card_atr_parse_and_match.sv =====
// Top level: answer-to-reset parser with card compatibility match.
// Takes one answer-to-reset byte per cycle while input is not stalled. The parse
// of a byte is one combinational step from the phase and captured-field
// registers; the result of a final byte is registered in the result register,
// or in the skid register while the result register holds an untaken result,
// and offered on the output channel from the result register. Input stalls
// only when both hold untaken results, so one waiting result does not stall it.
`timescale 1ns / 1ps
module smart_card_atr_parse_and_match (
    input  logic         clk,
    input  logic         rst_n,
    atr_byte_if.sink     atr_bytes,
    atr_result_if.source atr_report
);

    logic                 take;
    logic                 push;
    logic                 can_push;
    atr_pkg::atr_result_t core_result;
    atr_pkg::atr_result_t res_data;

    assign atr_bytes.ready = can_push;
    assign take            = atr_bytes.valid && can_push;

    atr_parse_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .atr_byte  (atr_bytes.atr_byte),
        .last_byte (atr_bytes.last_byte),
        .push      (push),
        .result    (core_result)
    );

    atr_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (core_result),
        .can_push  (can_push),
        .res_valid (atr_report.valid),
        .res_ready (atr_report.ready),
        .res_data  (res_data)
    );

    assign atr_report.status                = res_data.status;
    assign atr_report.card_match            = res_data.card_match;
    assign atr_report.format_byte           = res_data.format_byte;
    assign atr_report.historical_count      = res_data.historical_count;
    assign atr_report.level_one_mask        = res_data.level_one_mask;
    assign atr_report.level_two_mask        = res_data.level_two_mask;
    assign atr_report.first_interface_byte  = res_data.first_interface_byte;
    assign atr_report.second_interface_byte = res_data.second_interface_byte;
    assign atr_report.third_interface_byte  = res_data.third_interface_byte;
    assign atr_report.fourth_interface_byte = res_data.fourth_interface_byte;

endmodule
